### rtl/i2cms_pkg.sv
// i2c master sequencer package: phase type, field widths and constants
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 8;
    localparam int TICK_W    = 8;
    localparam int BIT_IDX_W = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    localparam logic [LIMIT_W-1:0]   ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE     = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_SP_C    = 5'd6,
        PH_TX_LO   = 5'd7,
        PH_TX_HI   = 5'd8,
        PH_TX_TAIL = 5'd9,
        PH_WA_HI   = 5'd10,
        PH_WA_POLL = 5'd11,
        PH_RX_HI   = 5'd12,
        PH_RX_LO   = 5'd13,
        PH_AK_LO   = 5'd14,
        PH_AK_HI   = 5'd15,
        PH_NK_A    = 5'd16,
        PH_NK_B    = 5'd17,
        PH_NK_C    = 5'd18
    } phase_t;

    // extra ticks held in a segment after the one that enters it
    function automatic logic [TICK_W-1:0] seg_ticks(input phase_t p);
        if (p == PH_ST_A || p == PH_ST_B || p == PH_SP_A || p == PH_SP_C) begin
            seg_ticks = 8'd3;
        end else begin
            seg_ticks = 8'd1;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/i2c_master_sequencer_top.sv
// i2c master sequencer top level: tick driven bus sequencer with output register
`timescale 1ns / 1ps
`default_nettype none

// One input word is one bus tick; the block takes one word every clock cycle and
// returns one result word per input word, in the next cycle, from a single output
// register. The input side stalls only while that register holds a word that the
// output side has not taken. Commands are taken only when no command is running;
// counted from the accepting tick, start and stop stay busy for 10 ticks, a send
// byte 48, a read byte 36 with ACK or 38 with NACK, and an ack wait 3 ticks before
// its first poll, then one poll per tick, at most ack_timeout_limit + 1 of them (a
// timeout adds a stop); the tick after the last busy one pulses done_res.
module i2c_master_sequencer_top
    import i2cms_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [LIMIT_W-1:0]   cfg_data,      // ack_timeout_limit
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [S_DATA_W-1:0]  s_tdata,       // tx_byte, send_ack, sda_in, zero pad
    input  wire [CMD_W-1:0]     s_tuser,       // cmd
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata        // scl_level, sda_level, sda_drive_enable,
                                               // busy_res, done_res, rx_byte,
                                               // ack_failed, zero pad
);

    logic [LIMIT_W-1:0]   limit_reg;
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 want_ack_reg, want_ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 oe_reg, oe_next;
    logic                 fail_reg, fail_next;
    logic [BYTE_W-1:0]    rx_last_reg, rx_last_next;
    logic                 done_next;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    logic                 accept;
    cmd_t                 cmd;
    logic [BYTE_W-1:0]    tx_byte;
    logic                 send_ack;
    logic                 sda_in;
    logic [TICK_W:0]      poll_cnt;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [BYTE_W-1:0]    shift_up;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign cmd      = cmd_t'(s_tuser);
    assign tx_byte  = s_tdata[BYTE_W-1:0];
    assign send_ack = s_tdata[BYTE_W];
    assign sda_in   = s_tdata[BYTE_W+1];
    assign poll_cnt = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign bit_inc  = bit_reg + 4'd1;
    assign shift_up = {shift_reg[BYTE_W-2:0], 1'b0};

    // next state
    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        want_ack_next = want_ack_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        oe_next       = oe_reg;
        fail_next     = fail_reg;
        rx_last_next  = rx_last_reg;
        done_next     = 1'b0;
        if (accept) begin
            if (phase_reg == PH_IDLE) begin
                case (cmd)
                    CMD_START: begin
                        phase_next = PH_ST_A;
                        scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
                    end
                    CMD_STOP: begin
                        phase_next = PH_SP_A;
                        scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                    end
                    CMD_SEND: begin
                        shift_next = tx_byte;
                        bit_next   = '0;
                        phase_next = PH_TX_LO;
                        scl_next = 1'b0; sda_next = tx_byte[BYTE_W-1]; oe_next = 1'b1;
                    end
                    CMD_WACK: begin
                        fail_next  = 1'b0;
                        phase_next = PH_WA_HI;
                        scl_next = 1'b1; oe_next = 1'b0;
                    end
                    CMD_READ: begin
                        shift_next    = '0;
                        bit_next      = '0;
                        want_ack_next = send_ack;
                        phase_next    = PH_RX_HI;
                        scl_next = 1'b1; oe_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
                if (phase_next != PH_IDLE) begin
                    tick_next = seg_ticks(phase_next);
                end
            end else if (phase_reg == PH_WA_POLL) begin
                if (!sda_in) begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done_next  = 1'b1;
                end else if (poll_cnt > {1'b0, limit_reg}) begin
                    fail_next  = 1'b1;
                    phase_next = PH_SP_A;
                    scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                    tick_next  = seg_ticks(PH_SP_A);
                end else begin
                    tick_next = poll_cnt[TICK_W-1:0];
                end
            end else if (tick_reg != '0) begin
                tick_next = tick_reg - 8'd1;
            end else begin
                case (phase_reg)
                    PH_ST_A: begin
                        phase_next = PH_ST_B;
                        scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
                    end
                    PH_ST_B: begin
                        phase_next = PH_ST_C;
                        scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                    end
                    PH_SP_A: begin
                        phase_next = PH_SP_B;
                        scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
                    end
                    PH_SP_B: begin
                        phase_next = PH_SP_C;
                        scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
                    end
                    PH_ST_C, PH_SP_C: begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_TX_LO: begin
                        phase_next = PH_TX_HI;
                        scl_next = 1'b1; oe_next = 1'b1;
                    end
                    PH_TX_HI: begin
                        phase_next = PH_TX_TAIL;
                        scl_next = 1'b0; oe_next = 1'b1;
                    end
                    PH_TX_TAIL: begin
                        bit_next = bit_inc;
                        if (bit_inc < BITS_PER_BYTE) begin
                            shift_next = shift_up;
                            phase_next = PH_TX_LO;
                            scl_next = 1'b0; sda_next = shift_up[BYTE_W-1]; oe_next = 1'b1;
                        end else begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    PH_WA_HI: begin
                        phase_next = PH_WA_POLL;
                    end
                    PH_RX_HI: begin
                        shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                        phase_next = PH_RX_LO;
                        scl_next = 1'b0; oe_next = 1'b0;
                    end
                    PH_RX_LO: begin
                        bit_next = bit_inc;
                        if (bit_inc < BITS_PER_BYTE) begin
                            phase_next = PH_RX_HI;
                            scl_next = 1'b1; oe_next = 1'b0;
                        end else if (want_ack_reg) begin
                            phase_next = PH_AK_LO;
                            scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                        end else begin
                            phase_next = PH_NK_A;
                            scl_next = 1'b0; oe_next = 1'b1;
                        end
                    end
                    PH_AK_LO: begin
                        phase_next = PH_AK_HI;
                        scl_next = 1'b1; sda_next = 1'b0; oe_next = 1'b1;
                    end
                    PH_NK_A: begin
                        phase_next = PH_NK_B;
                        scl_next = 1'b0; sda_next = 1'b1; oe_next = 1'b1;
                    end
                    PH_NK_B: begin
                        phase_next = PH_NK_C;
                        scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
                    end
                    PH_AK_HI, PH_NK_C: begin
                        scl_next     = 1'b0;
                        rx_last_next = shift_reg;
                        phase_next   = PH_IDLE;
                        done_next    = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (phase_next == PH_IDLE || phase_next == PH_WA_POLL) begin
                    tick_next = '0;
                end else begin
                    tick_next = seg_ticks(phase_next);
                end
            end
        end
    end

    // result word
    always_comb begin
        m_data_next = '0;
        m_data_next[0] = scl_next;
        m_data_next[1] = sda_next;
        m_data_next[2] = oe_next;
        m_data_next[3] = (phase_next != PH_IDLE);
        m_data_next[4] = done_next;
        m_data_next[5 +: BYTE_W] = rx_last_next;
        m_data_next[5 + BYTE_W] = fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= ACK_TIMEOUT_RESET;
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            want_ack_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            oe_reg       <= 1'b1;
            fail_reg     <= 1'b0;
            rx_last_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            want_ack_reg <= want_ack_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            oe_reg       <= oe_next;
            fail_reg     <= fail_next;
            rx_last_reg  <= rx_last_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cms_checker.sv
// i2c master sequencer port checker and its bind
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker
    import i2cms_pkg::*;
(
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // output register free means input side open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // a finishing word never shows busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[3])
        else $error("done and busy in one word");

    // every accepted input word yields a result word next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word gave no result");

endmodule

bind i2c_master_sequencer_top i2cms_checker u_i2cms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/testbench.sv
// testbench for the i2c master sequencer: directed table plus random ticks against a predictor
`timescale 1ns / 1ps

module testbench;
    import i2cms_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam int PHASE_TICKS = 50;
    localparam int NUM_PHASES  = 6;

    typedef struct {
        bit       scl;
        bit       sda;
        bit       oe;
        bit       busy;
        bit       done;
        bit [7:0] rx;
        bit       fail;
    } bus_word_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [7:0]       tx;
        logic             ack;
        logic [6:0]       sda_pct;
        logic [CMD_W-1:0] busy_op;
        logic             chk_rx;
        logic [7:0]       want_rx;
        logic             chk_fail;
        logic             want_fail;
    } dir_row_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [CMD_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    i2c_master_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predicted sequencer state
    phase_t           ph;
    logic [TICK_W-1:0] ticks;
    logic [3:0]       bitn;
    logic [7:0]       shreg;
    logic             want_ack_q;
    logic             scl_q, sda_q, oe_q, fail_q, done_q;
    logic [7:0]       rx_q;
    logic [7:0]       limit_q;

    bus_word_t bus_words_due[$];
    int mismatches   = 0;
    int words_seen   = 0;
    int cmds_started = 0;
    int ack_timeouts = 0;
    int limits_used  = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int sda_hi_pct      = 50;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void enter_seg(phase_t p, logic scl, logic sda, logic oe);
        ph    = p;
        scl_q = scl;
        sda_q = sda;
        oe_q  = oe;
        ticks = (p == PH_ST_A || p == PH_ST_B || p == PH_SP_A || p == PH_SP_C) ? 8'd3 : 8'd1;
    endfunction

    function automatic void end_cmd();
        ph     = PH_IDLE;
        ticks  = '0;
        done_q = 1'b1;
    endfunction

    function automatic void reset_bus();
        ph = PH_IDLE;
        ticks = '0;
        bitn = '0;
        shreg = '0;
        want_ack_q = 1'b0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        oe_q = 1'b1;
        fail_q = 1'b0;
        done_q = 1'b0;
        rx_q = '0;
        limit_q = ACK_TIMEOUT_RESET;
    endfunction

    function automatic void next_segment(logic sd);
        case (ph)
            PH_ST_A: enter_seg(PH_ST_B, 1'b1, 1'b0, 1'b1);
            PH_ST_B: enter_seg(PH_ST_C, 1'b0, 1'b0, 1'b1);
            PH_ST_C: end_cmd();
            PH_SP_A: enter_seg(PH_SP_B, 1'b1, 1'b0, 1'b1);
            PH_SP_B: enter_seg(PH_SP_C, 1'b1, 1'b1, 1'b1);
            PH_SP_C: end_cmd();
            PH_TX_LO: enter_seg(PH_TX_HI, 1'b1, sda_q, 1'b1);
            PH_TX_HI: enter_seg(PH_TX_TAIL, 1'b0, sda_q, 1'b1);
            PH_TX_TAIL: begin
                bitn = bitn + 4'd1;
                if (bitn < 4'd8) begin
                    shreg = shreg << 1;
                    enter_seg(PH_TX_LO, 1'b0, shreg[7], 1'b1);
                end else begin
                    scl_q = 1'b0;
                    end_cmd();
                end
            end
            PH_WA_HI: begin
                ph    = PH_WA_POLL;
                ticks = '0;
            end
            PH_RX_HI: begin
                shreg = {shreg[6:0], sd};
                enter_seg(PH_RX_LO, 1'b0, sda_q, 1'b0);
            end
            PH_RX_LO: begin
                bitn = bitn + 4'd1;
                if (bitn < 4'd8) begin
                    enter_seg(PH_RX_HI, 1'b1, sda_q, 1'b0);
                end else if (want_ack_q) begin
                    enter_seg(PH_AK_LO, 1'b0, 1'b0, 1'b1);
                end else begin
                    enter_seg(PH_NK_A, 1'b0, sda_q, 1'b1);
                end
            end
            PH_AK_LO: enter_seg(PH_AK_HI, 1'b1, 1'b0, 1'b1);
            PH_NK_A: enter_seg(PH_NK_B, 1'b0, 1'b1, 1'b1);
            PH_NK_B: enter_seg(PH_NK_C, 1'b1, 1'b1, 1'b1);
            PH_AK_HI, PH_NK_C: begin
                scl_q = 1'b0;
                rx_q  = shreg;
                end_cmd();
            end
            default: begin
                ph    = PH_IDLE;
                ticks = '0;
            end
        endcase
    endfunction

    // one bus tick: returns the line levels and flags after the update
    function automatic bus_word_t step_bus(logic [CMD_W-1:0] c, logic [7:0] tx, logic ak,
                                           logic sd);
        bus_word_t w;
        done_q = 1'b0;
        if (ph == PH_IDLE) begin
            if (c >= CMD_START && c <= CMD_READ) cmds_started++;
            case (c)
                CMD_START: enter_seg(PH_ST_A, 1'b1, 1'b1, 1'b1);
                CMD_STOP:  enter_seg(PH_SP_A, 1'b0, 1'b0, 1'b1);
                CMD_SEND: begin
                    shreg = tx;
                    bitn  = '0;
                    enter_seg(PH_TX_LO, 1'b0, tx[7], 1'b1);
                end
                CMD_WACK: begin
                    fail_q = 1'b0;
                    enter_seg(PH_WA_HI, 1'b1, sda_q, 1'b0);
                end
                CMD_READ: begin
                    shreg      = '0;
                    bitn       = '0;
                    want_ack_q = ak;
                    enter_seg(PH_RX_HI, 1'b1, sda_q, 1'b0);
                end
                default: ;
            endcase
        end else if (ph == PH_WA_POLL) begin
            if (!sd) begin
                scl_q = 1'b0;
                end_cmd();
            end else if (int'(ticks) + 1 > int'(limit_q)) begin
                fail_q = 1'b1;
                ack_timeouts++;
                enter_seg(PH_SP_A, 1'b0, 1'b0, 1'b1);
            end else begin
                ticks = ticks + 8'd1;
            end
        end else if (ticks > 0) begin
            ticks = ticks - 8'd1;
        end else begin
            next_segment(sd);
        end
        w.scl  = scl_q;
        w.sda  = sda_q;
        w.oe   = oe_q;
        w.busy = (ph != PH_IDLE);
        w.done = done_q;
        w.rx   = rx_q;
        w.fail = fail_q;
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on word %0d, %s: got %0d, want %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    // result side: random stall and compare
    always @(posedge aclk) begin
        bus_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bus_words_due.size() == 0) begin
                flag_mismatch("unexpected word", m_tdata, 0);
            end else begin
                want = bus_words_due.pop_front();
                if (m_tdata[0] != want.scl) flag_mismatch("scl_level", m_tdata[0], want.scl);
                if (m_tdata[1] != want.sda) flag_mismatch("sda_level", m_tdata[1], want.sda);
                if (m_tdata[2] != want.oe)
                    flag_mismatch("sda_drive_enable", m_tdata[2], want.oe);
                if (m_tdata[3] != want.busy) flag_mismatch("busy_res", m_tdata[3], want.busy);
                if (m_tdata[4] != want.done) flag_mismatch("done_res", m_tdata[4], want.done);
                if (m_tdata[12:5] != want.rx) flag_mismatch("rx_byte", m_tdata[12:5], want.rx);
                if (m_tdata[13] != want.fail)
                    flag_mismatch("ack_failed", m_tdata[13], want.fail);
            end
            words_seen++;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic push_tick(input logic [CMD_W-1:0] c, input logic [7:0] tx, input logic ak,
                             input logic sd);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {6'd0, sd, ak, tx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bus_words_due.push_back(step_bus(c, tx, ak, sd));
    endtask

    function automatic logic sda_draw();
        return ($urandom_range(0, 99) < sda_hi_pct);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (bus_words_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        limit_q = v;
        limits_used++;
    endtask

    // op, tx, ack, sda high %, op sent while busy, typed rx / fail at the finishing tick
    dir_row_t steps [19] = '{
        '{CMD_NONE,  8'h00, 1'b0, 7'd0,   CMD_NONE,  1'b1, 8'h00, 1'b1, 1'b0},
        '{CMD_START, 8'h00, 1'b0, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_SEND,  8'hFF, 1'b0, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_SEND,  8'h00, 1'b1, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_SEND,  8'hA5, 1'b0, 7'd50,  CMD_READ,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_WACK,  8'h00, 1'b0, 7'd0,   CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_WACK,  8'h3C, 1'b1, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_READ,  8'h00, 1'b1, 7'd100, CMD_NONE,  1'b1, 8'hFF, 1'b1, 1'b0},
        '{CMD_READ,  8'hFF, 1'b0, 7'd0,   CMD_NONE,  1'b1, 8'h00, 1'b1, 1'b0},
        '{CMD_READ,  8'h5A, 1'b1, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_WACK,  8'h00, 1'b0, 7'd100, CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b1},
        '{CMD_WACK,  8'h00, 1'b0, 7'd0,   CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_STOP,  8'h00, 1'b0, 7'd50,  CMD_NONE,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_RSVD6, 8'hFF, 1'b1, 7'd100, CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_RSVD7, 8'h00, 1'b0, 7'd0,   CMD_NONE,  1'b0, 8'h00, 1'b1, 1'b0},
        '{CMD_START, 8'h00, 1'b0, 7'd50,  CMD_STOP,  1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_STOP,  8'h00, 1'b0, 7'd50,  CMD_START, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CMD_READ,  8'h00, 1'b0, 7'd100, CMD_WACK,  1'b1, 8'hFF, 1'b1, 1'b0},
        '{CMD_NONE,  8'h00, 1'b0, 7'd50,  CMD_NONE,  1'b1, 8'hFF, 1'b1, 1'b0}
    };

    int        phase_limit [NUM_PHASES];
    int        idle_mode   [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{7, 7}};

    initial begin
        bus_word_t last;
        int        n;
        int        r;
        logic [CMD_W-1:0] c;

        reset_bus();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset limit
        foreach (steps[i]) begin
            sda_hi_pct = int'(steps[i].sda_pct);
            push_tick(steps[i].op, steps[i].tx, steps[i].ack, sda_draw());
            while (ph != PH_IDLE)
                push_tick(steps[i].busy_op, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), sda_draw());
            last = bus_words_due.pop_back();
            if (steps[i].chk_rx) last.rx = steps[i].want_rx;
            if (steps[i].chk_fail) last.fail = steps[i].want_fail;
            bus_words_due.push_back(last);
        end
        wait_drained();

        phase_limit = '{0, 1, 255, $urandom_range(2, 40), 250, $urandom_range(1, 255)};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(8'(phase_limit[p]));
            sender_idle_pct = idle_mode[p % 4][0];
            recv_stall_pct  = idle_mode[p % 4][1];
            n = 0;
            while (n < PHASE_TICKS) begin
                if (p == 1 && n == PHASE_TICKS / 2) wait_drained();
                if (ph == PH_IDLE) begin
                    r = $urandom_range(0, 99);
                    if (r < 10)      c = CMD_START;
                    else if (r < 20) c = CMD_STOP;
                    else if (r < 45) c = CMD_SEND;
                    else if (r < 65) c = CMD_WACK;
                    else if (r < 88) c = CMD_READ;
                    else if (r < 94) c = CMD_NONE;
                    else if (r < 97) c = CMD_RSVD6;
                    else             c = CMD_RSVD7;
                    case ($urandom_range(0, 4))
                        0: sda_hi_pct = 0;
                        1: sda_hi_pct = 25;
                        2: sda_hi_pct = 50;
                        3: sda_hi_pct = 90;
                        default: sda_hi_pct = (p == 2) ? 90 : 100;
                    endcase
                end else begin
                    c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
                end
                push_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          sda_draw());
                n++;
            end
            while (ph != PH_IDLE)
                push_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          sda_draw());
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("ran %0d ticks: %0d commands, %0d ack timeouts, %0d timeout limits",
                 words_seen, cmds_started, ack_timeouts, limits_used);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
